// ----- src/mexp_pkg.sv -----
// Package for the modular exponentiation block: operand width, register map,
// reset value of the modulus register. No dependencies.
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS);
  localparam int FIELD_BITS   = 32;
  localparam int ADDR_BITS    = 3;

  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(23);

  typedef logic [OPERAND_BITS-1:0] operand_t;

endpackage

// ----- src/mexp_mulmod.sv -----
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg. Requires b < m and m >= 2.
`timescale 1ns / 1ps
module mexp_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mexp_pkg::operand_t a,
  input  mexp_pkg::operand_t b,
  input  mexp_pkg::operand_t m,
  output logic              done,
  output mexp_pkg::operand_t result
);
  import mexp_pkg::*;

  localparam int SW = OPERAND_BITS + 3;

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  operand_t            a_sh;
  operand_t            mcand;
  operand_t            acc;

  logic [SW-1:0] sum;
  logic [SW-1:0] diff1;
  logic [SW-1:0] diff2;
  operand_t      acc_next;

  always_comb begin
    sum   = {2'b00, acc, 1'b0} + (a_sh[OPERAND_BITS-1] ? SW'(mcand) : '0);
    diff1 = sum - SW'(m);
    diff2 = sum - {2'b00, m, 1'b0};
    if (!diff2[SW-1]) begin
      acc_next = diff2[OPERAND_BITS-1:0];
    end else if (!diff1[SW-1]) begin
      acc_next = diff1[OPERAND_BITS-1:0];
    end else begin
      acc_next = sum[OPERAND_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      mcand <= b;
      acc   <= '0;
      cnt   <= CNT_BITS'(OPERAND_BITS - 1);
    end else if (busy) begin
      a_sh <= {a_sh[OPERAND_BITS-2:0], 1'b0};
      acc  <= acc_next;
      cnt  <= cnt - 1'b1;
    end
  end

  assign result = acc;

endmodule

// ----- src/modular_exponentiation.sv -----
// Usage: modular exponentiation, power_result = base_value ^ exponent_value mod modulus.
// Slave stream s_* takes one beat {exponent_value, base_value}; master stream m_*
// returns one beat with power_result for each accepted input beat.
// The modulus register sits at APB byte address 0 (reset value 23); write it only
// while the block is idle. Moduli 0 and 1 yield 0 without running the multipliers.
// The base is first reduced by the modulus in the multiply unit, then each exponent bit
// up to the highest set one is handled in a step: the square and the conditional
// multiply run in two bit-serial multipliers side by side, one multiplier bit per cycle.
// An exponent of 0 skips the steps; one item is in work at a time.
// s_tready is high while no item is in work. A finished result waits in the output
// register; while it is held the next item can already be taken and computed, and
// that item parks until the output register drains.
// Reset (rst, synchronous) drops any item in work and any pending result, and
// restores the modulus to 23.
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps
module modular_exponentiation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] base_value, [63:32] exponent_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] power_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mexp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_STEP   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state;
  logic [FIELD_BITS-1:0] modulus;
  operand_t              base_q;
  operand_t              acc_q;
  operand_t              exp_sh;
  operand_t              res_q;

  operand_t op_mod;
  logic     mod_small;
  logic     in_beat;
  logic     cfg_wr;

  logic     mul_start;
  operand_t mul_a;
  operand_t mul_b;
  logic     mul_done;
  operand_t mul_res;
  logic     sq_start;
  logic     sq_done;
  operand_t sq_res;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_MODULUS) ? modulus : '0;
  assign op_mod    = modulus[OPERAND_BITS-1:0];
  assign mod_small = op_mod < OPERAND_BITS'(2);
  assign s_tready  = (state == ST_IDLE);
  assign in_beat   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_wr && paddr[2] == REG_MODULUS) begin
      modulus <= pwdata;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = base_q;
    mul_b     = acc_q;
    sq_start  = 1'b0;
    if (state == ST_IDLE) begin
      mul_start = in_beat && !mod_small;
      mul_a     = s_tdata[OPERAND_BITS-1:0];
      mul_b     = OPERAND_BITS'(1);
    end else if (state == ST_STEP && exp_sh != '0) begin
      mul_start = exp_sh[0];
      sq_start  = 1'b1;
    end
  end

  mexp_mulmod u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (op_mod),
    .done   (mul_done),
    .result (mul_res)
  );

  mexp_mulmod u_sq (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .a      (base_q),
    .b      (base_q),
    .m      (op_mod),
    .done   (sq_done),
    .result (sq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= mod_small ? ST_FINISH : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= (exp_sh == '0) ? ST_FINISH : ST_MUL;
        end
        ST_MUL: begin
          if (sq_done) begin
            state <= ST_STEP;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        exp_sh <= s_tdata[32 +: OPERAND_BITS];
        res_q  <= '0;
      end
      ST_REDUCE: begin
        if (mul_done) begin
          base_q <= mul_res;
          acc_q  <= OPERAND_BITS'(1);
        end
      end
      ST_STEP: begin
        if (exp_sh == '0) begin
          res_q <= acc_q;
        end
      end
      ST_MUL: begin
        if (sq_done) begin
          base_q <= sq_res;
          exp_sh <= exp_sh >> 1;
          if (exp_sh[0]) begin
            acc_q <= mul_res;
          end
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= FIELD_BITS'(res_q);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && sq_done && exp_sh[0]) |-> mul_done)
    else $error("multiply and square units out of step");

  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (base_q < op_mod && acc_q < op_mod))
    else $error("operand not reduced by modulus");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_REDUCE || state == ST_FINISH))
    else $error("accepted beat did not start work");

  a_reduce_short: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE) |-> !sq_done)
    else $error("square unit active during base reduction");
`endif

endmodule

// ----- tb/sv/modular_exponentiation_test.sv -----
// Self-checking testbench for modular_exponentiation: directed table, then random beats
// under several moduli; typed rows hold their expected power, others use the in-bench
// square-and-multiply predictor. Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps
module modular_exponentiation_test;
  import mexp_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 1200;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 33;
  localparam logic [ADDR_BITS-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR = 3'd4;

  typedef struct {
    operand_t modulus;
    operand_t base;
    operand_t exponent;
    bit       typed;
    operand_t power;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // [31:0] base_value, [63:32] exponent_value
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;       // [31:0] power_result
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  operand_t power_q[$];
  operand_t mod_shadow = MODULUS_RESET;
  int errors = 0;
  bit hold_req = 1'b0;
  int send_calm = 0;

  modular_exponentiation DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("modular_exponentiation_test: errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // right-to-left square-and-multiply, exact 64-bit products
  function automatic operand_t mod_power(input operand_t b, input operand_t e,
                                         input operand_t m);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [63:0] mm;
    if (m < 2) return '0;
    mm = m;
    sq = b % mm;
    acc = 1;
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return operand_t'(acc);
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == MODULUS_ADDR) mod_shadow = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_modulus();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MODULUS_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== mod_shadow)
      flag_error($sformatf("modulus read %h, want %h", prdata, mod_shadow));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_beat(input operand_t b, input operand_t e, input bit typed,
                           input operand_t power);
    int gap;
    gap = draw_wait(send_calm);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {e, b};
    do @(posedge clk); while (!s_tready);
    power_q.push_back(typed ? power : mod_power(b, e, mod_shadow));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic operand_t pick_base(input operand_t m);
    case ($urandom_range(0, 9))
      6: return '0;
      7: return '1;
      8: return m + operand_t'($urandom_range(0, 2)) - 1;
      9: return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic operand_t pick_exponent();
    case ($urandom_range(0, 9))
      6: return '0;
      7: return '1;
      8: return $urandom_range(0, 16);
      9: return operand_t'(1) << $urandom_range(0, OPERAND_BITS - 1);
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    int calm;
    operand_t want;
    calm = 0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = draw_wait(calm);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (power_q.size() == 0) begin
        flag_error($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = power_q.pop_front();
        if (m_tdata !== want)
          flag_error($sformatf("power_result %h, want %h", m_tdata, want));
      end
    end
  end

  initial begin
    vector_t table_rows[] = '{
      '{23, 0, 0, 1'b1, 1},
      '{23, 5, 0, 1'b1, 1},
      '{23, 2, 1, 1'b1, 2},
      '{23, 2, 11, 1'b1, 1},
      '{23, 5, 3, 1'b1, 10},
      '{23, 23, 5, 1'b1, 0},
      '{23, 0, 5, 1'b1, 0},
      '{23, 32'hFFFFFFFF, 1, 1'b1, 11},
      '{23, 22, 2, 1'b1, 1},
      '{23, 22, 32'hFFFFFFFF, 1'b1, 22},
      '{23, 1, 32'hFFFFFFFF, 1'b1, 1},
      '{23, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0},
      '{23, 32'h80000000, 32'h80000000, 1'b0, 0},
      '{0, 5, 3, 1'b1, 0},
      '{0, 0, 0, 1'b1, 0},
      '{1, 0, 0, 1'b1, 0},
      '{1, 7, 9, 1'b1, 0},
      '{2, 3, 32'hFFFFFFFF, 1'b1, 1},
      '{2, 4, 1, 1'b1, 0},
      '{32'hFFFFFFFF, 32'hFFFFFFFE, 2, 1'b1, 1},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 3, 1'b1, 0},
      '{32'hFFFFFFFF, 2, 32, 1'b1, 1},
      '{32'hFFFFFFFF, 32'h12345678, 32'h9ABCDEF0, 1'b0, 0}
    };
    operand_t phase_mod[PHASES];
    operand_t m;

    phase_mod[0] = 32'hFFFFFFFB;
    phase_mod[1] = 32'h80000000;
    phase_mod[2] = 32'd65537;
    phase_mod[3] = $urandom;
    phase_mod[4] = 32'd3;
    phase_mod[5] = $urandom_range(2, 1000);
    phase_mod[6] = 32'hFFFFFFFF;
    phase_mod[7] = ~phase_mod[3];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_modulus();

    foreach (table_rows[i]) begin
      if (table_rows[i].modulus != mod_shadow) begin
        drain();
        apb_write(MODULUS_ADDR, table_rows[i].modulus);
        check_modulus();
      end
      send_beat(table_rows[i].base, table_rows[i].exponent, table_rows[i].typed,
                table_rows[i].power);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apb_write(MODULUS_ADDR, phase_mod[p]);
      if (p == 3) apb_write(SPARE_ADDR, $urandom);
      check_modulus();
      if (p == 0) hold_req = 1'b1;
      m = mod_shadow;
      repeat (PHASE_BEATS) send_beat(pick_base(m), pick_exponent(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && power_q.size() == 0) begin
      $display("modular_exponentiation_test: clean");
    end else begin
      $display("modular_exponentiation_test: errors");
    end
    $finish;
  end

endmodule
